/* hdl/qpd_pkg.sv */
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared constants, types and tables of the quaternion PD attitude torque core.
// ----------------------------------------------------------------------------
package qpd_pkg;

    // cordic iteration count and its index width
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CIW               = $clog2(CORDIC_ITERATIONS);

    // iterative unit step counts
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 64;

    // operation codes of the input word
    localparam logic OP_RATE = 1'b0;
    localparam logic OP_ATT  = 1'b1;

    // configuration register indexes
    localparam logic CFG_KP = 1'b0;
    localparam logic CFG_KD = 1'b1;

    // fixed point constants
    localparam logic [31:0]        GAIN_RESET   = 32'd76800000;
    localparam logic [63:0]        ONE_Q30      = 64'd1 << 30;
    localparam logic [63:0]        ERR_LIMIT    = 64'd1 << 33;
    localparam logic [63:0]        ONE_SQ_Q60   = 64'd1 << 60;
    localparam logic [30:0]        SIN_EPS      = 31'd1073;
    localparam logic signed [57:0] OUT_MAX      = (58'sd1 <<< 47) - 58'sd1;
    localparam logic signed [57:0] OUT_MIN      = -(58'sd1 <<< 47);

    // atan(2^-i) in Q0.30, first entries
    localparam logic [29:0] ATAN_HEAD [10] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149
    };

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_SQ    = 3'd0,
        MUL_EW    = 3'd1,
        MUL_THETA = 3'd2,
        MUL_KP    = 3'd3,
        MUL_KD    = 3'd4
    } t_mul_sel;

    typedef enum logic {
        SQRT_NORM = 1'b0,
        SQRT_SIN  = 1'b1
    } t_sqrt_sel;

    typedef enum logic {
        DIV_NORM = 1'b0,
        DIV_ERR  = 1'b1
    } t_div_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic            load_att;
        logic            load_rate;
        logic            acc_en;
        logic            mul_en;
        t_mul_sel        mul_sel;
        logic            sqrt_start;
        t_sqrt_sel       sqrt_sel;
        logic            store_s;
        logic            div_start;
        t_div_sel        div_sel;
        logic            store_c;
        logic            zero_c;
        logic            cordic_init;
        logic            cordic_step;
        logic            theta_en;
        logic            store_e;
        logic            store_p;
        logic            store_sum;
        logic            out_load;
        logic [1:0]      k;
        logic [CIW-1:0]  iter;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic norm_zero;
        logic sqrt_done;
        logic div_done;
        logic small_sin;
    } t_dp_stat;

    // cordic angle table entry
    function automatic logic [29:0] atan_entry(input logic [CIW-1:0] idx);
        logic [29:0] v;
        v = '0;
        if (int'(idx) < 10) begin
            v = ATAN_HEAD[idx];
        end else if (int'(idx) < 31) begin
            v = 30'((32'd1 << (30 - int'(idx))) - 32'd1);
        end
        return v;
    endfunction

endpackage

/* hdl/qpd_sqrt.sv */
// ----------------------------------------------------------------------------
// qpd_sqrt
// Iterative integer square root, floor of sqrt of a 64-bit value, one root
// bit per cycle.
// ----------------------------------------------------------------------------
module qpd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    import qpd_pkg::*;

    localparam int CW = $clog2(SQRT_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_rad;
    logic [33:0]   r_rem;
    logic [31:0]   r_root;

    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;

    // one digit pair per step
    always_comb begin
        rem_sh = {r_rem[31:0], r_rad[63:62]};
        trial  = {r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // root and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/qpd_div.sv */
// ----------------------------------------------------------------------------
// qpd_div
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    import qpd_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_num;
    logic [31:0]   r_den;
    logic [32:0]   r_rem;
    logic [63:0]   r_quo;

    logic [32:0] rem_sh;
    logic        ge;

    // trial subtract
    always_comb begin
        rem_sh = {r_rem[31:0], r_num[63]};
        ge     = (rem_sh >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hdl/qpd_dp.sv */
// ----------------------------------------------------------------------------
// qpd_dp
// Datapath: held rates, gains, shared multiplier, square root and divider,
// cordic vectoring registers, torque terms and the output register.
// ----------------------------------------------------------------------------
module qpd_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qpd_pkg::t_dp_cmd    i_cmd,
    output qpd_pkg::t_dp_stat   o_stat,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [15:0]  i_quat_w,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    input  logic signed [31:0]  i_rate_x,
    input  logic signed [31:0]  i_rate_y,
    input  logic signed [31:0]  i_rate_z,
    output logic signed [47:0]  o_torque_x,
    output logic signed [47:0]  o_torque_y,
    output logic signed [47:0]  o_torque_z
);
    import qpd_pkg::*;

    logic [31:0]        r_kp;
    logic [31:0]        r_kd;
    logic signed [31:0] r_rate [3];
    logic signed [15:0] r_q    [4];
    logic [32:0]        r_acc;
    logic signed [65:0] r_prod;
    logic [31:0]        r_s;
    logic [30:0]        r_c    [4];
    logic [30:0]        r_sh;
    logic signed [34:0] r_x;
    logic signed [34:0] r_y;
    logic signed [32:0] r_z;
    logic [31:0]        r_theta;
    logic signed [24:0] r_e20;
    logic signed [45:0] r_p;
    logic signed [47:0] r_tq   [3];
    logic signed [47:0] r_out  [3];

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [1:0]         vi;
    logic [15:0]        qmag;
    logic [63:0]        sqrt_rad;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic [63:0]        div_num;
    logic [31:0]        div_den;
    logic               div_done;
    logic [63:0]        div_quo;
    logic [30:0]        c_new;
    logic               vneg;
    logic [33:0]        err_mag;
    logic signed [34:0] e30;
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic signed [32:0] atn;
    logic signed [57:0] diff;
    logic signed [57:0] sat;

    // vector component index and quaternion magnitude
    always_comb begin
        vi   = i_cmd.k + 2'd1;
        qmag = r_q[i_cmd.k][15] ? (~r_q[i_cmd.k] + 16'd1) : r_q[i_cmd.k];
    end

    // shared multiplier operand selection
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                mul_a = 33'(r_q[i_cmd.k]);
                mul_b = 33'(r_q[i_cmd.k]);
            end
            MUL_EW: begin
                mul_a = $signed({2'b00, r_c[0]});
                mul_b = $signed({2'b00, r_c[0]});
            end
            MUL_THETA: begin
                mul_a = $signed({1'b0, r_theta});
                mul_b = $signed({2'b00, r_c[vi]});
            end
            MUL_KP: begin
                mul_a = $signed({1'b0, r_kp});
                mul_b = 33'(r_e20);
            end
            MUL_KD: begin
                mul_a = $signed({1'b0, r_kd});
                mul_b = 33'(r_rate[i_cmd.k]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // iterative unit inputs
    always_comb begin
        if (i_cmd.sqrt_sel == SQRT_NORM) begin
            sqrt_rad = {1'b0, r_acc, 30'd0};
        end else begin
            sqrt_rad = ONE_SQ_Q60 - {3'b000, r_prod[60:0]};
        end
        if (i_cmd.div_sel == DIV_NORM) begin
            div_num = {3'b000, qmag, 45'd0};
            div_den = r_s;
        end else begin
            div_num = r_prod[63:0];
            div_den = {1'b0, r_sh};
        end
    end

    qpd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (sqrt_rad),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    qpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // normalized component, error term, cordic step and torque sum
    always_comb begin
        c_new   = (div_quo > ONE_Q30) ? ONE_Q30[30:0] : div_quo[30:0];
        vneg    = r_q[vi][15] ^ ~r_q[0][15];
        err_mag = (div_quo > ERR_LIMIT) ? ERR_LIMIT[33:0] : div_quo[33:0];
        e30     = vneg ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
        dx      = r_x >>> i_cmd.iter;
        dy      = r_y >>> i_cmd.iter;
        atn     = $signed({3'b000, atan_entry(i_cmd.iter)});
        diff    = 58'(r_p) - 58'(r_prod >>> 8);
        if (diff > OUT_MAX) begin
            sat = OUT_MAX;
        end else if (diff < OUT_MIN) begin
            sat = OUT_MIN;
        end else begin
            sat = diff;
        end
    end

    // gains and held rates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= GAIN_RESET;
            r_kd      <= GAIN_RESET;
            r_rate[0] <= '0;
            r_rate[1] <= '0;
            r_rate[2] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KP:  r_kp <= i_cfg_data;
                    CFG_KD:  r_kd <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_rate) begin
                r_rate[0] <= i_rate_x;
                r_rate[1] <= i_rate_y;
                r_rate[2] <= i_rate_z;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_att) begin
            r_q[0] <= i_quat_w;
            r_q[1] <= i_quat_x;
            r_q[2] <= i_quat_y;
            r_q[3] <= i_quat_z;
            r_acc  <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + r_prod[32:0];
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.store_s) begin
            r_s <= sqrt_root;
        end
        if (i_cmd.zero_c) begin
            r_c[0] <= '0;
            r_c[1] <= '0;
            r_c[2] <= '0;
            r_c[3] <= '0;
        end else if (i_cmd.store_c) begin
            r_c[i_cmd.k] <= c_new;
        end
        // cordic vectoring on (ew, sin_half)
        if (i_cmd.cordic_init) begin
            r_sh <= sqrt_root[30:0];
            r_x  <= $signed({4'b0000, r_c[0]});
            r_y  <= $signed({4'b0000, sqrt_root[30:0]});
            r_z  <= '0;
        end else if (i_cmd.cordic_step) begin
            if (r_y > 35'sd0) begin
                r_x <= r_x + dy;
                r_y <= r_y - dx;
                r_z <= r_z + atn;
            end else begin
                r_x <= r_x - dy;
                r_y <= r_y + dx;
                r_z <= r_z - atn;
            end
        end
        if (i_cmd.theta_en) begin
            r_theta <= r_z[32] ? 32'd0 : {r_z[30:0], 1'b0};
        end
        if (i_cmd.store_e) begin
            r_e20 <= o_stat.small_sin ? 25'sd0 : 25'(e30 >>> 10);
        end
        if (i_cmd.store_p) begin
            r_p <= 46'(r_prod >>> 12);
        end
        if (i_cmd.store_sum) begin
            r_tq[i_cmd.k] <= 48'(sat);
        end
        if (i_cmd.out_load) begin
            r_out[0] <= r_tq[0];
            r_out[1] <= r_tq[1];
            r_out[2] <= r_tq[2];
        end
    end

    // status
    always_comb begin
        o_stat.norm_zero = (r_acc == 33'd0);
        o_stat.sqrt_done = sqrt_done;
        o_stat.div_done  = div_done;
        o_stat.small_sin = (r_sh <= SIN_EPS);
    end

    assign o_torque_x = r_out[0];
    assign o_torque_y = r_out[1];
    assign o_torque_z = r_out[2];

endmodule

/* hdl/qpd_ctrl.sv */
// ----------------------------------------------------------------------------
// qpd_ctrl
// Controller: sequences one attitude word through the shared datapath units
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module qpd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output qpd_pkg::t_dp_cmd   o_cmd,
    input  qpd_pkg::t_dp_stat  i_stat
);
    import qpd_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_SQ_MUL  = 20'h00002,
        ST_SQ_ACC  = 20'h00004,
        ST_N_SQRT  = 20'h00008,
        ST_N_WAIT  = 20'h00010,
        ST_N_DIV   = 20'h00020,
        ST_N_DWAIT = 20'h00040,
        ST_EW_MUL  = 20'h00080,
        ST_S_SQRT  = 20'h00100,
        ST_S_WAIT  = 20'h00200,
        ST_CORDIC  = 20'h00400,
        ST_THETA   = 20'h00800,
        ST_E_MUL   = 20'h01000,
        ST_E_DIV   = 20'h02000,
        ST_E_WAIT  = 20'h04000,
        ST_E_STORE = 20'h08000,
        ST_P_MUL   = 20'h10000,
        ST_PD_MUL  = 20'h20000,
        ST_SUM     = 20'h40000,
        ST_OUT     = 20'h80000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic [1:0]     r_k;
    logic [1:0]     n_k;
    logic [CIW-1:0] r_iter;
    logic [CIW-1:0] n_iter;
    logic           r_out_valid;
    logic           in_acc;
    logic           out_acc;

    assign in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign out_acc = r_out_valid && !i_out_stall;

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_iter     = r_iter;
        o_cmd      = '0;
        o_cmd.k    = r_k;
        o_cmd.iter = r_iter;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_operation == OP_ATT) begin
                        o_cmd.load_att = 1'b1;
                        n_k            = 2'd0;
                        n_state        = ST_SQ_MUL;
                    end else begin
                        o_cmd.load_rate = 1'b1;
                    end
                end
            end
            ST_SQ_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
                n_state       = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (r_k == 2'd3) begin
                    n_k     = 2'd0;
                    n_state = ST_N_SQRT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_SQ_MUL;
                end
            end
            // zero quaternion skips normalization
            ST_N_SQRT: begin
                if (i_stat.norm_zero) begin
                    o_cmd.zero_c = 1'b1;
                    n_state      = ST_EW_MUL;
                end else begin
                    o_cmd.sqrt_start = 1'b1;
                    o_cmd.sqrt_sel   = SQRT_NORM;
                    n_state          = ST_N_WAIT;
                end
            end
            ST_N_WAIT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.store_s = 1'b1;
                    n_k           = 2'd0;
                    n_state       = ST_N_DIV;
                end
            end
            ST_N_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_NORM;
                n_state         = ST_N_DWAIT;
            end
            ST_N_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.store_c = 1'b1;
                    if (r_k == 2'd3) begin
                        n_k     = 2'd0;
                        n_state = ST_EW_MUL;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = ST_N_DIV;
                    end
                end
            end
            ST_EW_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_EW;
                n_state       = ST_S_SQRT;
            end
            ST_S_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                o_cmd.sqrt_sel   = SQRT_SIN;
                n_state          = ST_S_WAIT;
            end
            ST_S_WAIT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.cordic_init = 1'b1;
                    n_iter            = '0;
                    n_state           = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (r_iter == CIW'(CORDIC_ITERATIONS - 1)) begin
                    n_state = ST_THETA;
                end else begin
                    n_iter = r_iter + CIW'(1);
                end
            end
            ST_THETA: begin
                o_cmd.theta_en = 1'b1;
                n_k            = 2'd0;
                n_state        = ST_E_MUL;
            end
            // per axis: error term, then P and D products
            ST_E_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_THETA;
                n_state       = ST_E_DIV;
            end
            ST_E_DIV: begin
                if (i_stat.small_sin) begin
                    n_state = ST_E_STORE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_ERR;
                    n_state         = ST_E_WAIT;
                end
            end
            ST_E_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_E_STORE;
                end
            end
            ST_E_STORE: begin
                o_cmd.store_e = 1'b1;
                n_state       = ST_P_MUL;
            end
            ST_P_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KP;
                n_state       = ST_PD_MUL;
            end
            ST_PD_MUL: begin
                o_cmd.store_p = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KD;
                n_state       = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.store_sum = 1'b1;
                if (r_k == 2'd2) begin
                    n_state = ST_OUT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_E_MUL;
                end
            end
            // wait for a free output register
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_iter  <= n_iter;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // square root finishes only while it is awaited
    a_sqrt_done_awaited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.sqrt_done |-> (r_state == ST_N_WAIT || r_state == ST_S_WAIT))
        else $error("square root finished outside a wait state");

    // divider finishes only while it is awaited
    a_div_done_awaited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == ST_N_DWAIT || r_state == ST_E_WAIT))
        else $error("divider finished outside a wait state");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && r_out_valid) |-> !i_out_stall)
        else $error("output word overwritten while stalled");

    // an attitude word starts the sequence, a rate word does not
    a_att_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_ATT) |=> (r_state == ST_SQ_MUL))
        else $error("attitude word did not start the sequence");

    a_rate_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_RATE) |=> (r_state == ST_IDLE))
        else $error("rate word left idle");

endmodule

/* hdl/quaternion_pd_attitude_torque_core.sv */
// ----------------------------------------------------------------------------
// quaternion_pd_attitude_torque_core
// PD attitude torque controller toward the identity attitude.
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall): operation 0 stores the body rate
//   words and gives no result; operation 1 takes a Q1.15 quaternion and
//   computes one torque word (Q32.16, saturated) on the output channel
//   (o_out_valid / i_out_stall).
//   an attitude word runs through a sum of squares, a 32-step square root,
//   four 64-step divisions for normalization, a second square root,
//   CORDIC_ITERATIONS cordic steps, then per axis up to one 64-step division
//   and three products. the shared 64-step divider takes most of that work;
//   o_in_stall is high throughout. the finished word waits in an output
//   register: a new word is accepted while it is stalled, and the next result
//   waits until the register frees. the user must write gains through
//   i_cfg_we / i_cfg_index / i_cfg_data only while idle; the block does not
//   enforce it. reset clears the held rates to zero, sets both gains to
//   300000.0 and empties the output register.
// ----------------------------------------------------------------------------
module quaternion_pd_attitude_torque_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [31:0] i_rate_x,
    input  logic signed [31:0] i_rate_y,
    input  logic signed [31:0] i_rate_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_torque_x,
    output logic signed [47:0] o_torque_y,
    output logic signed [47:0] o_torque_z
);
    import qpd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    qpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // arithmetic and storage
    qpd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_quat_w    (i_quat_w),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_rate_x    (i_rate_x),
        .i_rate_y    (i_rate_y),
        .i_rate_z    (i_rate_z),
        .o_torque_x  (o_torque_x),
        .o_torque_y  (o_torque_y),
        .o_torque_z  (o_torque_z)
    );

endmodule
